// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define CHK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ffba_pkg.sv -----
// Package for the first-fit block allocator: sizes, codes and the table entry type.
// It has no dependencies.
`default_nettype none

package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 24;
   localparam int ADDR_W       = 24;
   localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

   localparam logic [ADDR_W-1:0] HEAP_RESET = ADDR_W'(10485760);
   localparam logic [ADDR_W:0]   HDR_EXT    = (ADDR_W + 1)'(HEADER_BYTES);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_DOUBLE  = 2'd2,
      ST_NOSPACE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] size;
      logic              is_free;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator: APB register, block table and scan sequencer.
// It depends on ffba_pkg and on assert_macros.svh for its checks.
//
// Channel  | Direction | Handshake        | Contents
// req_*    | in        | tvalid / tready  | tdata: req_size, free_addr; tuser: cmd
// rsp_*    | out       | tvalid / tready  | tdata: result_addr, status
// csr_*    | in/out    | psel / penable   | heap_bytes at byte address 0
//
// An item's scan reads the table entries, up to MAX_BLOCKS of them, one entry per cycle through
// the registered table read; no new item is taken until the scan of the last one has ended.
// A free or an allocate that reuses a block stops at the matching entry.
// After reset the table is empty and heap_bytes is 10 MiB; no clearing pass is needed.
// A new item is taken while a result waits; the scan holds at its end until rsp_tready.
`default_nettype none

module first_fit_block_allocator_unit
   import ffba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // [23:0] req_size, [47:24] free_addr
   input  wire logic        req_tuser,   // [0] cmd
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [23:0] result_addr, [25:24] status, zero above
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   localparam logic REG_HEAP_BYTES = 1'b0;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  chk_ff, chk_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [ADDR_W-1:0] heap_ff, heap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   entry_type         mem [MAX_BLOCKS];
   entry_type         rd_ff;

   logic              cfg_write;
   logic              accept;
   logic [ADDR_W:0]   payload;
   logic [ADDR_W-1:0] end_payload;
   logic [ADDR_W+1:0] new_end;
   logic              fits;
   logic              hit;
   logic              scan_end;
   logic              out_free;
   logic              issue;
   logic              finish;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_HEAP_BYTES) ? {8'd0, heap_ff} : 32'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_addr_ff};

   assign payload     = {1'b0, rd_ff.offset} + HDR_EXT;
   assign end_payload = ADDR_W'({1'b0, end_ff} + HDR_EXT);
   assign new_end     = {2'b00, end_ff} + {1'b0, HDR_EXT} + {2'b00, size_ff};
   assign fits        = (count_ff < CNT_W'(MAX_BLOCKS)) && (new_end <= {2'b00, heap_ff});

   always_comb begin
      if (cmd_ff == CMD_ALLOC) begin
         hit = pend_ff && rd_ff.is_free && (rd_ff.size >= size_ff);
      end else begin
         hit = pend_ff && (payload == {1'b0, faddr_ff});
      end
   end

   assign scan_end = !pend_ff && (scan_ff >= count_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issue    = (state_ff == S_SCAN) && !hit && (scan_ff < count_ff);
   assign finish   = (state_ff == S_SCAN) && (hit || scan_end) && out_free;

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = chk_ff;
      wr_data       = rd_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      count_in      = count_ff;
      end_in        = end_ff;
      if (finish) begin
         if (hit) begin
            if (cmd_ff == CMD_ALLOC) begin
               wr_en           = 1'b1;
               wr_data.is_free = 1'b0;
               rsp_addr_in     = payload[ADDR_W-1:0];
               rsp_status_in   = ST_OK;
            end else begin
               rsp_addr_in = '0;
               if (rd_ff.is_free) begin
                  rsp_status_in = ST_DOUBLE;
               end else begin
                  wr_en           = 1'b1;
                  wr_data.is_free = 1'b1;
                  rsp_status_in   = ST_OK;
               end
            end
         end else if (cmd_ff == CMD_ALLOC) begin
            if (fits) begin
               wr_en           = 1'b1;
               wr_addr         = count_ff[IDX_W-1:0];
               wr_data.offset  = end_ff;
               wr_data.size    = size_ff;
               wr_data.is_free = 1'b0;
               rsp_addr_in     = end_payload;
               rsp_status_in   = ST_OK;
               count_in        = count_ff + 1'b1;
               end_in          = new_end[ADDR_W-1:0];
            end else begin
               rsp_addr_in   = '0;
               rsp_status_in = ST_NOSPACE;
            end
         end else begin
            rsp_addr_in   = '0;
            rsp_status_in = ST_UNKNOWN;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      size_in      = size_ff;
      faddr_in     = faddr_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      pend_in      = pend_ff;
      heap_in      = heap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cfg_write && (csr_paddr[2] == REG_HEAP_BYTES)) begin
         heap_in = csr_pwdata[ADDR_W-1:0];
      end
      if (accept) begin
         state_in = S_SCAN;
         cmd_in   = cmd_type'(req_tuser);
         size_in  = req_tdata[23:0];
         faddr_in = req_tdata[47:24];
         scan_in  = '0;
         pend_in  = 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (issue) begin
            scan_in = scan_ff + 1'b1;
            chk_in  = scan_ff[IDX_W-1:0];
            pend_in = 1'b1;
         end else if (!hit) begin
            pend_in = 1'b0;
         end
         if (finish) begin
            state_in     = S_IDLE;
            pend_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         end_ff       <= '0;
         heap_ff      <= HEAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         heap_ff      <= heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

`include "assert_macros.svh"

   `CHK_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_BLOCKS), "block count above table size")
   `CHK_NEXT(a_rsp_from_scan, state_ff != S_SCAN, !$rose(rsp_valid_ff), "result without a scan")
   `CHK_IMPL(a_append_ok, count_ff != $past(count_ff), rsp_valid_ff && (rsp_status_ff == ST_OK),
             "table grew without a successful allocate")
   `CHK_NEXT(a_scan_stall, (state_ff == S_SCAN) && hit && !out_free,
             (state_ff == S_SCAN) && $stable(chk_ff), "scan moved while result blocked")

endmodule

`default_nettype wire
